// File: design/t2u8_pkg.sv
`default_nettype none

package t2u8_pkg;

   // source encodings
   localparam logic [1:0] ENC_LATIN1 = 2'd0;
   localparam logic [1:0] ENC_UTF8   = 2'd1;
   localparam logic [1:0] ENC_UTF16  = 2'd2;

   // position within the start of a string
   localparam logic [1:0] START_FIRST  = 2'd0;
   localparam logic [1:0] START_HELD1  = 2'd1;
   localparam logic [1:0] START_HELD2  = 2'd2;
   localparam logic [1:0] START_STREAM = 2'd3;

   localparam logic [7:0] BOM8_B0 = 8'hEF;
   localparam logic [7:0] BOM8_B1 = 8'hBB;
   localparam logic [7:0] BOM8_B2 = 8'hBF;
   localparam logic [7:0] BOM16_FF = 8'hFF;
   localparam logic [7:0] BOM16_FE = 8'hFE;

   localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [20:0] CP_MAX         = 21'h10FFFF;
   localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;

   localparam int MAX_BYTES = 6;
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);

   typedef struct packed {
      logic [2:0]      n;
      logic [3:0][7:0] b;
   } utf8_seq_type;

   // one code point to one to four UTF-8 bytes; surrogates and out-of-range give U+FFFD
   function automatic utf8_seq_type utf8_encode(input logic [20:0] cp_raw);
      logic [20:0]  cp;
      utf8_seq_type r;
      cp = cp_raw;
      if ((cp >= 21'h00D800 && cp <= 21'h00DFFF) || cp > CP_MAX) cp = CP_REPLACEMENT;
      r.b = '0;
      if (cp < 21'h000080) begin
         r.n    = 3'd1;
         r.b[0] = {1'b0, cp[6:0]};
      end else if (cp < 21'h000800) begin
         r.n    = 3'd2;
         r.b[0] = {3'b110, cp[10:6]};
         r.b[1] = {2'b10, cp[5:0]};
      end else if (cp < CP_SUPP_BASE) begin
         r.n    = 3'd3;
         r.b[0] = {4'b1110, cp[15:12]};
         r.b[1] = {2'b10, cp[11:6]};
         r.b[2] = {2'b10, cp[5:0]};
      end else begin
         r.n    = 3'd4;
         r.b[0] = {5'b11110, cp[20:18]};
         r.b[1] = {2'b10, cp[17:12]};
         r.b[2] = {2'b10, cp[11:6]};
         r.b[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/text_to_utf8_transcoder.sv
`default_nettype none

// Text to UTF-8 transcoder. Source bytes arrive one per beat on req_, with the
// encoding on req_tuser sampled at the first byte of each string and req_tlast
// closing the string; UTF-8 bytes leave one per beat on rsp_, with rsp_tlast on
// the final byte caused by an input byte and rsp_tuser on it when that input
// byte closed the string. A byte is taken into an input register, converted in
// one pass into a burst of up to six result bytes, then drained through the
// single-byte result port. Each input byte yields zero to six result bytes,
// typically one to three, with the result port setting the sustained rate; bytes
// that yield nothing do not wait for it. Each byte is held in the input register
// and its burst in the result buffer. Input is taken while the previous burst drains.
module text_to_utf8_transcoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic [1:0] req_tuser,   // [1:0] encoding
   input  wire logic       req_tlast,   // last_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] utf8_byte
   output logic            rsp_tuser,   // end_of_string
   output logic            rsp_tlast    // last_of_run
);
   import t2u8_pkg::*;

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic [1:0] in_enc_ff;
   logic       in_last_ff;

   // string state
   logic [1:0] enc_ff, enc_in;
   logic [1:0] start_ff, start_in;
   logic       be_ff, be_in;
   logic [7:0] half_ff, half_in;
   logic       half_vld_ff, half_vld_in;
   logic [9:0] hi_ff, hi_in;
   logic       hi_vld_ff, hi_vld_in;

   // result burst
   logic [MAX_BYTES-1:0][7:0] buf_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [CNT_W-1:0]          idx_ff;
   logic                      eos_ff;
   logic                      buf_vld_ff;

   logic [1:0]                enc;
   logic [1:0]                a_n;
   logic [2:0][7:0]           a_b;
   logic                      b_use;
   logic [20:0]               b_cp;
   logic [15:0]               unit;
   logic                      bom;
   logic                      paired;
   utf8_seq_type              seq;
   logic [2:0]                b_n;
   logic [CNT_W-1:0]          res_n;
   logic [MAX_BYTES-1:0][7:0] res;
   logic [2:0]                j;

   logic pop, pop_last, move;

   always_comb begin
      enc         = (start_ff == START_FIRST) ? in_enc_ff : enc_ff;
      enc_in      = enc;
      start_in    = start_ff;
      be_in       = be_ff;
      half_in     = half_ff;
      half_vld_in = half_vld_ff;
      hi_in       = hi_ff;
      hi_vld_in   = hi_vld_ff;
      a_n         = 2'd0;
      a_b         = '0;
      b_use       = 1'b0;
      b_cp        = '0;
      bom         = 1'b0;
      paired      = 1'b0;
      unit        = be_ff ? {half_ff, in_byte_ff} : {in_byte_ff, half_ff};

      case (enc)
         ENC_LATIN1: begin
            start_in = START_STREAM;
            b_use    = 1'b1;
            b_cp     = {13'd0, in_byte_ff};
         end
         ENC_UTF8: begin
            case (start_ff)
               START_FIRST: begin
                  if (in_byte_ff == BOM8_B0) begin
                     start_in = START_HELD1;
                  end else begin
                     a_n      = 2'd1;
                     a_b[0]   = in_byte_ff;
                     start_in = START_STREAM;
                  end
               end
               START_HELD1: begin
                  if (in_byte_ff == BOM8_B1) begin
                     start_in = START_HELD2;
                  end else begin
                     a_n      = 2'd2;
                     a_b[0]   = BOM8_B0;
                     a_b[1]   = in_byte_ff;
                     start_in = START_STREAM;
                  end
               end
               START_HELD2: begin
                  if (in_byte_ff != BOM8_B2) begin
                     a_n    = 2'd3;
                     a_b[0] = BOM8_B0;
                     a_b[1] = BOM8_B1;
                     a_b[2] = in_byte_ff;
                  end
                  start_in = START_STREAM;
               end
               default: begin
                  a_n    = 2'd1;
                  a_b[0] = in_byte_ff;
               end
            endcase
            // a partial mark still held at the end of the string is flushed
            if (in_last_ff && start_in == START_HELD1) begin
               a_n    = 2'd1;
               a_b[0] = BOM8_B0;
            end else if (in_last_ff && start_in == START_HELD2) begin
               a_n    = 2'd2;
               a_b[0] = BOM8_B0;
               a_b[1] = BOM8_B1;
            end
         end
         ENC_UTF16: begin
            if (!half_vld_ff) begin
               half_in     = in_byte_ff;
               half_vld_in = 1'b1;
               if (start_ff == START_FIRST) start_in = START_HELD1;
            end else begin
               half_vld_in = 1'b0;
               if (start_ff == START_HELD1) begin
                  start_in = START_STREAM;
                  if (half_ff == BOM16_FF && in_byte_ff == BOM16_FE) begin
                     be_in = 1'b0;
                     bom   = 1'b1;
                  end else if (half_ff == BOM16_FE && in_byte_ff == BOM16_FF) begin
                     bom = 1'b1;
                  end
               end
               if (!bom) begin
                  if (hi_vld_ff) begin
                     hi_vld_in = 1'b0;
                     if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
                        paired = 1'b1;
                        b_use  = 1'b1;
                        b_cp   = CP_SUPP_BASE + {1'b0, hi_ff, unit[9:0]};
                     end else begin
                        // unpaired high surrogate: U+FFFD ahead of this unit
                        a_n    = 2'd3;
                        a_b[0] = 8'hEF;
                        a_b[1] = 8'hBF;
                        a_b[2] = 8'hBD;
                     end
                  end
                  if (!paired) begin
                     if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
                        hi_in     = unit[9:0];
                        hi_vld_in = 1'b1;
                     end else begin
                        b_use = 1'b1;
                        b_cp  = {5'd0, unit};
                     end
                  end
               end
            end
            if (in_last_ff && hi_vld_in) begin
               hi_vld_in = 1'b0;
               b_use     = 1'b1;
               b_cp      = CP_REPLACEMENT;
            end
         end
         default: begin
            start_in = START_STREAM;
         end
      endcase

      if (in_last_ff) begin
         start_in    = START_FIRST;
         be_in       = 1'b1;
         half_vld_in = 1'b0;
         hi_vld_in   = 1'b0;
      end
   end

   // fixed bytes first, then the encoded code point
   always_comb begin
      seq   = utf8_encode(b_cp);
      b_n   = b_use ? seq.n : 3'd0;
      res_n = CNT_W'({1'b0, a_n} + b_n);
      res   = '0;
      j     = '0;
      for (int i = 0; i < MAX_BYTES; i++) begin
         j = 3'(i) - {1'b0, a_n};
         if (3'(i) < {1'b0, a_n}) begin
            res[i] = a_b[i[1:0]];
         end else if (j < 3'd4) begin
            res[i] = seq.b[j[1:0]];
         end
      end
   end

   assign rsp_tvalid = buf_vld_ff;
   assign rsp_tdata  = buf_ff[idx_ff];
   assign rsp_tlast  = (idx_ff == cnt_ff - CNT_W'(1));
   assign rsp_tuser  = eos_ff & rsp_tlast;

   assign pop        = rsp_tvalid & rsp_tready;
   assign pop_last   = pop & rsp_tlast;
   assign move       = in_vld_ff & (!buf_vld_ff | pop_last | (res_n == '0));
   assign req_tready = !in_vld_ff | move;
   assign in_vld_in  = (req_tvalid & req_tready) | (in_vld_ff & !move);

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_enc_ff  <= req_tuser;
         in_last_ff <= req_tlast;
      end
      if (move) begin
         half_ff <= half_in;
         hi_ff   <= hi_in;
      end
      if (move && res_n != '0) begin
         buf_ff <= res;
         cnt_ff <= res_n;
         eos_ff <= in_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         buf_vld_ff  <= 1'b0;
         idx_ff      <= '0;
         enc_ff      <= ENC_LATIN1;
         start_ff    <= START_FIRST;
         be_ff       <= 1'b1;
         half_vld_ff <= 1'b0;
         hi_vld_ff   <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (move) begin
            enc_ff      <= enc_in;
            start_ff    <= start_in;
            be_ff       <= be_in;
            half_vld_ff <= half_vld_in;
            hi_vld_ff   <= hi_vld_in;
         end
         if (move && res_n != '0) begin
            buf_vld_ff <= 1'b1;
            idx_ff     <= '0;
         end else if (pop_last) begin
            buf_vld_ff <= 1'b0;
         end else if (pop) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// File: design/t2u8_checker.sv
`default_nettype none

module t2u8_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tuser,
   input wire logic       rsp_tlast
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // end of string only ever marks the closing beat of a burst
   a_eos_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end of string without end of burst");

   // after reset the block is empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not empty after reset");

endmodule

bind text_to_utf8_transcoder t2u8_checker u_t2u8_checker (.*);

`default_nettype wire
